// File: rtl/qvn_pkg.sv
package qvn_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_BITS_DEF = 16;

  typedef struct packed {
    logic signed [DATA_W-1:0] in_x;
    logic signed [DATA_W-1:0] in_y;
    logic signed [DATA_W-1:0] in_z;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] norm_x;
    logic signed [DATA_W-1:0] norm_y;
    logic signed [DATA_W-1:0] norm_z;
  } out_res_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic sq_step;
    logic sum_step;
    logic rt_init;
    logic rt_step;
    logic dv_init;
    logic dv_step;
    logic zero_out;
    logic [1:0] comp;
  } qvn_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sum_bad;
    logic len_bad;
  } qvn_sts_t;

endpackage

// File: rtl/q16_vec3_normalize.sv
// sequence (Q16.16 by default): load, square and sum each component, root of the sum, divide each component
// a sum of squares that is zero or negative skips root and divide: the result is zero
// a new vector is taken only while idle; busy is high from the accept until the result
// root and divide use one bit-serial root loop and one shared bit-serial divider
// reset: synchronous active-low rst_n returns the sequencer to idle; the receiver cannot stall
module q16_vec3_normalize #(
  parameter int FRAC_BITS = qvn_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  qvn_pkg::in_req_t  in_req,
  output logic             out_valid,
  output qvn_pkg::out_res_t out_res
);
  import qvn_pkg::*;

  qvn_cmd_t cmd;
  qvn_sts_t sts;

  qvn_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .out_valid(out_valid), .cmd(cmd), .sts(sts)
  );

  qvn_dpath #(.FRAC_BITS(FRAC_BITS)) u_dpath (
    .clk(clk), .in_req(in_req), .cmd(cmd), .sts(sts), .out_res(out_res)
  );

  // no start taken while busy
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !busy) else $error("load while busy");
  // a result ends the item
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy after result");
  // root and divide never overlap
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.rt_step && cmd.dv_step)) else $error("root and divide overlap");

endmodule

// File: rtl/qvn_ctrl.sv
module qvn_ctrl #(
  parameter int FRAC_BITS = qvn_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output logic             out_valid,
  output qvn_pkg::qvn_cmd_t cmd,
  input  qvn_pkg::qvn_sts_t sts
);
  import qvn_pkg::*;

  localparam int RT_STEPS = (DATA_W + FRAC_BITS + 1) / 2;
  localparam int DV_STEPS = DATA_W + FRAC_BITS;
  localparam int CNT_W = $clog2(DV_STEPS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_RT   = 3'd3;
  localparam logic [2:0] S_DVI  = 3'd4;
  localparam logic [2:0] S_DV   = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0] comp_r, comp_nxt;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    comp_nxt = comp_r;
    cmd = '0;
    cmd.comp = comp_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          comp_nxt = 2'd0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.sq_step = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (comp_r == 2'd2) begin
          state_nxt = S_RT;
          cnt_nxt = '0;
        end else begin
          comp_nxt = comp_r + 2'd1;
          state_nxt = S_SQ;
        end
      end
      S_RT: begin
        if (cnt_r == '0) begin
          if (sts.sum_bad) begin
            cmd.zero_out = 1'b1;
            state_nxt = S_DONE;
          end else begin
            cmd.rt_init = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
        end else begin
          cmd.rt_step = 1'b1;
          if (cnt_r == CNT_W'(RT_STEPS)) begin
            comp_nxt = 2'd0;
            state_nxt = S_DVI;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      S_DVI: begin
        if (sts.len_bad) begin
          cmd.zero_out = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.dv_init = 1'b1;
          cnt_nxt = '0;
          state_nxt = S_DV;
        end
      end
      S_DV: begin
        cmd.dv_step = 1'b1;
        if (cnt_r == CNT_W'(DV_STEPS - 1)) begin
          if (comp_r == 2'd2) begin
            state_nxt = S_DONE;
          end else begin
            comp_nxt = comp_r + 2'd1;
            state_nxt = S_DVI;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      comp_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      comp_r <= comp_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

// File: rtl/qvn_dpath.sv
module qvn_dpath #(
  parameter int FRAC_BITS = qvn_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  qvn_pkg::in_req_t  in_req,
  input  qvn_pkg::qvn_cmd_t cmd,
  output qvn_pkg::qvn_sts_t sts,
  output qvn_pkg::out_res_t out_res
);
  import qvn_pkg::*;

  localparam int RW = DATA_W + FRAC_BITS + 1;      // radicand width plus one; halved below to round up to even
  localparam int RT_STEPS = RW / 2;
  localparam int NW = DATA_W + FRAC_BITS;          // dividend magnitude width
  localparam int PW = 2 * DATA_W;

  logic signed [DATA_W-1:0] vec_r [3];
  logic [DATA_W-1:0] mag_sel;
  logic [PW-1:0] prod_r;
  logic [DATA_W-1:0] sum_r;
  logic [2*RT_STEPS-1:0] rad_r;
  logic [RT_STEPS+1:0] rem_r;
  logic [RT_STEPS-1:0] root_r;
  logic [NW-1:0] num_r;
  logic [DATA_W:0] drem_r;
  logic neg_r;
  logic [DATA_W-1:0] res_r [3];
  logic [PW-1:0] sq_rnd;
  logic [RT_STEPS+1:0] rt_trial;
  logic [RT_STEPS+1:0] rt_sub;
  logic [DATA_W:0] dv_trial;
  logic [DATA_W:0] dv_sub;
  logic [DATA_W-1:0] q_lo;
  logic [NW-1:0] num_mag;

  // magnitude of selected component, its rounded square and its shifted dividend
  always_comb begin
    mag_sel = vec_r[cmd.comp][DATA_W-1] ? DATA_W'(-vec_r[cmd.comp]) : vec_r[cmd.comp];
    sq_rnd = (prod_r + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    num_mag = NW'(mag_sel) << FRAC_BITS;
  end

  // restoring root: two radicand bits per step; restoring divide: one dividend bit per step
  always_comb begin
    rt_trial = {rem_r[RT_STEPS-1:0], rad_r[2*RT_STEPS-1 -: 2]};
    rt_sub = rt_trial - {root_r, 2'b01};
    dv_trial = {drem_r[DATA_W-1:0], num_r[NW-1]};
    dv_sub = dv_trial - (DATA_W+1)'(root_r);
    q_lo = num_r[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vec_r[0] <= in_req.in_x;
      vec_r[1] <= in_req.in_y;
      vec_r[2] <= in_req.in_z;
      sum_r <= '0;
    end
    if (cmd.sq_step) prod_r <= PW'(mag_sel) * PW'(mag_sel);
    if (cmd.sum_step) sum_r <= sum_r + sq_rnd[DATA_W-1:0];
    if (cmd.rt_init) begin
      rad_r <= (2*RT_STEPS)'({sum_r, FRAC_BITS'(0)});
      rem_r <= '0;
      root_r <= '0;
    end
    if (cmd.rt_step) begin
      rad_r <= rad_r << 2;
      if (!rt_sub[RT_STEPS+1]) begin
        rem_r <= rt_sub;
        root_r <= {root_r[RT_STEPS-2:0], 1'b1};
      end else begin
        rem_r <= rt_trial;
        root_r <= {root_r[RT_STEPS-2:0], 1'b0};
      end
    end
    if (cmd.dv_init) begin
      num_r <= num_mag;
      drem_r <= '0;
      neg_r <= vec_r[cmd.comp][DATA_W-1];
    end
    if (cmd.dv_step) begin
      if (!dv_sub[DATA_W]) begin
        drem_r <= dv_sub;
        num_r <= {num_r[NW-2:0], 1'b1};
      end else begin
        drem_r <= dv_trial;
        num_r <= {num_r[NW-2:0], 1'b0};
      end
    end
    if (cmd.zero_out) begin
      res_r[0] <= '0;
      res_r[1] <= '0;
      res_r[2] <= '0;
    end else if (cmd.dv_init && cmd.comp != 2'd0) begin
      res_r[cmd.comp - 2'd1] <= neg_r ? DATA_W'(-q_lo) : q_lo;
    end else if (cmd.dv_step == 1'b0 && cmd.comp == 2'd2 && !cmd.dv_init && !cmd.rt_step
                 && !cmd.sq_step && !cmd.sum_step && !cmd.load && !cmd.rt_init) begin
      res_r[2] <= neg_r ? DATA_W'(-q_lo) : q_lo;
    end
  end

  // status
  assign sts.sum_bad = (sum_r == '0) || sum_r[DATA_W-1];
  assign sts.len_bad = (root_r == '0) || (RT_STEPS > DATA_W - 1 && root_r[RT_STEPS-1]);

  assign out_res.norm_x = res_r[0];
  assign out_res.norm_y = res_r[1];
  assign out_res.norm_z = (cmd.comp == 2'd2 && !sts.sum_bad && !sts.len_bad)
                          ? (neg_r ? DATA_W'(-q_lo) : q_lo) : res_r[2];

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import qvn_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int LATENCY = 200;
  localparam longint CYCLE_LIMIT = 4 * 1500 * (LATENCY + 40) + 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_req_t in_req = '0;
  logic out_valid;
  out_res_t out_res;

  int fail_count = 0;
  longint cycle_count = 0;
  int sender_idle_pct = 0;

  q16_vec3_normalize dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_res(out_res)
  );

  always #1 clk = ~clk;

  // rounded square, low 32 bits
  function automatic logic [31:0] round_square(logic signed [31:0] a);
    logic [63:0] mag;
    logic [63:0] prod;
    mag = (a < 0) ? 64'(-64'(signed'(a))) : 64'(a);
    prod = mag * mag;
    return 32'((prod + (64'd1 << (FRAC - 1))) >> FRAC);
  endfunction

  // truncating restoring root of (v << FRAC)
  function automatic logic [63:0] vec_length(logic [31:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bitv;
    rem = 64'(v) << FRAC;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [31:0] scaled_quotient(logic signed [31:0] a, logic [63:0] len);
    longint num;
    longint q;
    num = longint'(a) * (longint'(1) << FRAC);
    q = num / longint'(len);
    return q[31:0];
  endfunction

  function automatic out_res_t unit_vector(in_req_t r);
    out_res_t res;
    logic [31:0] sum;
    logic [63:0] len;
    res = '0;
    sum = round_square(r.in_x) + round_square(r.in_y) + round_square(r.in_z);
    if (sum != 0 && !sum[31]) begin
      len = vec_length(sum) & 64'hFFFF_FFFF;
      if (len != 0 && len <= 64'h7FFF_FFFF) begin
        res.norm_x = scaled_quotient(r.in_x, len);
        res.norm_y = scaled_quotient(r.in_y, len);
        res.norm_z = scaled_quotient(r.in_z, len);
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
    fail_count++;
  endtask

  class norm_scoreboard;
    out_res_t pending[$];

    function void note_request(in_req_t r);
      pending.push_back(unit_vector(r));
    endfunction

    task check_result(out_res_t got);
      out_res_t want;
      if (pending.size() == 0) begin
        $display("unexpected result at cycle %0d", cycle_count);
        fail_count++;
      end else begin
        want = pending.pop_front();
        if (got.norm_x !== want.norm_x) report_mismatch("norm_x", got.norm_x, want.norm_x);
        if (got.norm_y !== want.norm_y) report_mismatch("norm_y", got.norm_y, want.norm_y);
        if (got.norm_z !== want.norm_z) report_mismatch("norm_z", got.norm_z, want.norm_z);
      end
    endtask
  endclass

  norm_scoreboard sb = new();

  // sample handshakes and results at the edge
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (start && !busy) sb.note_request(in_req);
      if (out_valid) sb.check_result(out_res);
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout");
      $display("testbench: FAIL");
      $finish;
    end
  end

  // one request, with random idle cycles ahead of it; start stays high after the accept
  task automatic send_request(in_req_t r);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [31:0] random_component();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'(signed'($urandom_range(0, 32'h1FFFF)) - 32'sh10000);
      2: return 32'(signed'($urandom_range(0, 32'hFFFFFF)) - 32'sh800000);
      3: return 32'(signed'($urandom_range(0, 32'h3FFF)) - 32'sh2000);
      4: return {{24{1'b0}}, 8'($urandom)};
      default: return 32'(signed'($urandom_range(0, 32'h1FFFFFF)) - 32'sh1000000);
    endcase
  endfunction

  // stop requesting and wait for every expected result
  task automatic drain_results();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic signed [31:0] corners[7];
    in_req_t r;
    corners = '{32'sh0, 32'sh1, -32'sh1, 32'sh10000, -32'sh10000,
                32'sh7FFFFFFF, 32'sh80000000};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero, unit axes, tiny, huge/wrapping, negative sum
    for (int i = 0; i < 21; i++) begin
      r.in_x = corners[i % 7];
      r.in_y = corners[(i / 7 + i) % 7];
      r.in_z = corners[(i * 3) % 7];
      send_request(r);
    end
    send_request('{32'sh0, 32'sh0, 32'sh0});
    send_request('{32'sh0, 32'sh0, -32'sh30000});
    send_request('{32'sh5A827, 32'sh5A827, 32'sh0});
    send_request('{32'sh00B504F3, 32'sh0, 32'sh0});

    // random phases with different idle patterns
    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 77 : 0;
      for (int n = 0; n < 475; n++) begin
        r.in_x = random_component();
        r.in_y = random_component();
        r.in_z = random_component();
        send_request(r);
      end
      drain_results();
    end

    drain_results();
    repeat (LATENCY) @(posedge clk);
    if (fail_count == 0 && sb.pending.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
